[hw/rtl/bpq_pkg.sv]
// bpq_pkg: shared types, constants and helpers for the bucket priority queue
package bpq_pkg;

    localparam int LEVELS     = 16;
    localparam int LVL_W      = 4;
    localparam int CAPACITY   = 64;
    localparam int PTR_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    typedef enum logic [1:0] {
        K_ENQ,
        K_DEQ,
        K_BAD
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK,
        ST_LEVEL,
        ST_FULL,
        ST_EMPTY
    } t_status;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_ENQ_FREE,
        BS_DEQ_LINK,
        BS_VAL
    } t_bstate;

    typedef struct packed {
        t_kind             kind;
        logic [LVL_W-1:0]  level;
    } t_cmd;

    typedef struct packed {
        t_status           status;
        logic              is_empty;
        logic [CNT_W-1:0]  count;
        logic [LVL_W-1:0]  front_level;
    } t_res;

    typedef struct packed {
        logic              found;
        logic [LVL_W-1:0]  idx;
    } t_find;

    // lowest set bit of the occupancy mask
    function automatic t_find first_set(input logic [LEVELS-1:0] mask);
        t_find f;
        f = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (mask[i]) begin
                f.found = 1'b1;
                f.idx   = LVL_W'(i);
            end
        end
        return f;
    endfunction

    function automatic logic [PTR_W-1:0] next_node(input logic [PTR_W-1:0] a);
        return (a == PTR_W'(CAPACITY - 1)) ? '0 : a + 1'b1;
    endfunction

endpackage

[hw/rtl/bpq_cmd_fifo.sv]
// bpq_cmd_fifo: short request queue between the front and back parts
module bpq_cmd_fifo #(
    parameter int W = 38
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_vld,
    output logic [W-1:0] o_data
);
    import bpq_pkg::*;

    logic [W-1:0]       r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wptr;
    logic [FIFO_AW-1:0] r_rptr;
    logic [FIFO_AW:0]   r_fill;

    assign o_full = (r_fill == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_vld  = (r_fill != '0);
    assign o_data = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

[hw/rtl/bpq_front.sv]
// bpq_front: request intake, level limit register and request classification
module bpq_front #(
    parameter int ELEM_WIDTH = 32,
    parameter int IN_W       = 40
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [3:0]            i_cfg_wdata,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [IN_W-1:0]       i_data,
    input  logic                  i_user,
    output logic                  o_push,
    output bpq_pkg::t_cmd         o_cmd,
    output logic [ELEM_WIDTH-1:0] o_elem,
    input  logic                  i_full
);
    import bpq_pkg::*;

    logic [LVL_W-1:0]      r_lowest_level;
    logic                  r_vld;
    t_cmd                  r_cmd;
    logic [ELEM_WIDTH-1:0] r_elem;
    t_cmd                  n_cmd;
    logic                  take;

    assign o_push  = r_vld && !i_full;
    assign o_ready = !r_vld || !i_full;
    assign take    = i_valid && o_ready;
    assign o_cmd   = r_cmd;
    assign o_elem  = r_elem;

    always_comb begin
        n_cmd.level = i_data[ELEM_WIDTH +: LVL_W];
        if (i_user == CMD_DEQ) begin
            n_cmd.kind = K_DEQ;
        end else if (n_cmd.level > r_lowest_level) begin
            n_cmd.kind = K_BAD;
        end else begin
            n_cmd.kind = K_ENQ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lowest_level <= LVL_W'(LEVELS - 1);
            r_vld          <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_lowest_level <= i_cfg_wdata;
            end
            if (take) begin
                r_vld <= 1'b1;
            end else if (o_push) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd  <= n_cmd;
            r_elem <= i_data[ELEM_WIDTH-1:0];
        end
    end

endmodule

[hw/rtl/bpq_back.sv]
// bpq_back: level lists, node pool, free list and result generation
module bpq_back #(
    parameter int ELEM_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_vld,
    input  bpq_pkg::t_cmd         i_cmd,
    input  logic [ELEM_WIDTH-1:0] i_elem,
    output logic                  o_pop,
    input  logic                  i_slot_free,
    output logic                  o_emit,
    output bpq_pkg::t_res         o_res,
    output logic [ELEM_WIDTH-1:0] o_res_elem
);
    import bpq_pkg::*;

    // node pool
    logic [ELEM_WIDTH-1:0] r_val_mem [CAPACITY];
    logic [PTR_W-1:0]      r_lk_mem  [CAPACITY];
    logic [CAPACITY-1:0]   r_lk_vld;
    logic [ELEM_WIDTH-1:0] r_val_rd;
    logic [PTR_W-1:0]      r_lk_rd;
    logic [PTR_W-1:0]      r_lk_rd_addr;
    logic                  r_lk_rd_vld;

    // per level pointers
    logic [PTR_W-1:0]      r_head [LEVELS];
    logic [PTR_W-1:0]      r_tail [LEVELS];

    t_bstate               r_state, n_state;
    logic [LEVELS-1:0]     r_nonempty, n_nonempty;
    logic [PTR_W-1:0]      r_free, n_free;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [LVL_W-1:0]      r_front_lvl, n_front_lvl;
    logic [PTR_W-1:0]      r_front_node, n_front_node;
    logic [ELEM_WIDTH-1:0] r_front_elem, n_front_elem;

    logic                  val_we, val_re, lk_we, lk_re, hd_we, tl_we;
    logic [PTR_W-1:0]      val_waddr, val_raddr, lk_waddr, lk_wdata, lk_raddr;
    logic [ELEM_WIDTH-1:0] val_wdata;
    logic [LVL_W-1:0]      hd_idx, tl_idx, tl_ridx, hd_ridx;
    logic [PTR_W-1:0]      hd_data, tl_data, tl_rd, hd_rd, lk_q;
    t_status               status;
    t_find                 nxt;

    assign lk_q    = r_lk_rd_vld ? r_lk_rd : next_node(r_lk_rd_addr);
    assign tl_ridx = (i_cmd.kind == K_ENQ) ? i_cmd.level : r_front_lvl;
    assign tl_rd   = r_tail[tl_ridx];
    assign nxt     = first_set(r_nonempty & ~(LEVELS'(1) << r_front_lvl));
    assign hd_ridx = nxt.idx;
    assign hd_rd   = r_head[hd_ridx];

    always_comb begin
        n_state      = r_state;
        n_nonempty   = r_nonempty;
        n_free       = r_free;
        n_count      = r_count;
        n_front_lvl  = r_front_lvl;
        n_front_node = r_front_node;
        n_front_elem = r_front_elem;
        val_we       = 1'b0;
        val_re       = 1'b0;
        lk_we        = 1'b0;
        lk_re        = 1'b0;
        hd_we        = 1'b0;
        tl_we        = 1'b0;
        val_waddr    = r_free;
        val_wdata    = i_elem;
        val_raddr    = hd_rd;
        lk_waddr     = tl_rd;
        lk_wdata     = r_free;
        lk_raddr     = r_free;
        hd_idx       = i_cmd.level;
        hd_data      = r_free;
        tl_idx       = i_cmd.level;
        tl_data      = r_free;
        status       = ST_OK;
        o_pop        = 1'b0;
        o_emit       = 1'b0;
        case (r_state)
            BS_IDLE: begin
                if (i_cmd_vld && i_slot_free) begin
                    o_pop = 1'b1;
                    case (i_cmd.kind)
                        K_ENQ: begin
                            if (r_count == CNT_W'(CAPACITY)) begin
                                status = ST_FULL;
                                o_emit = 1'b1;
                            end else begin
                                val_we = 1'b1;
                                if (r_nonempty[i_cmd.level]) begin
                                    lk_we = 1'b1;
                                end else begin
                                    hd_we = 1'b1;
                                end
                                tl_we                   = 1'b1;
                                n_nonempty[i_cmd.level] = 1'b1;
                                n_count                 = r_count + 1'b1;
                                lk_re                   = 1'b1;
                                if (r_count == '0 || i_cmd.level < r_front_lvl) begin
                                    n_front_elem = i_elem;
                                    n_front_lvl  = i_cmd.level;
                                    n_front_node = r_free;
                                end
                                n_state = BS_ENQ_FREE;
                            end
                        end
                        K_DEQ: begin
                            if (r_count == '0) begin
                                status = ST_EMPTY;
                                o_emit = 1'b1;
                            end else begin
                                lk_we    = 1'b1;
                                lk_waddr = r_front_node;
                                lk_wdata = r_free;
                                n_free   = r_front_node;
                                n_count  = r_count - 1'b1;
                                if (tl_rd == r_front_node) begin
                                    n_nonempty[r_front_lvl] = 1'b0;
                                    if (nxt.found) begin
                                        val_re       = 1'b1;
                                        n_front_lvl  = nxt.idx;
                                        n_front_node = hd_rd;
                                        n_state      = BS_VAL;
                                    end else begin
                                        n_front_elem = '0;
                                        n_front_lvl  = '0;
                                        o_emit       = 1'b1;
                                    end
                                end else begin
                                    lk_re    = 1'b1;
                                    lk_raddr = r_front_node;
                                    n_state  = BS_DEQ_LINK;
                                end
                            end
                        end
                        default: begin
                            status = ST_LEVEL;
                            o_emit = 1'b1;
                        end
                    endcase
                end
            end
            BS_ENQ_FREE: begin
                n_free  = lk_q;
                o_emit  = 1'b1;
                n_state = BS_IDLE;
            end
            BS_DEQ_LINK: begin
                hd_we        = 1'b1;
                hd_idx       = r_front_lvl;
                hd_data      = lk_q;
                n_front_node = lk_q;
                val_re       = 1'b1;
                val_raddr    = lk_q;
                n_state      = BS_VAL;
            end
            BS_VAL: begin
                n_front_elem = r_val_rd;
                o_emit       = 1'b1;
                n_state      = BS_IDLE;
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    assign o_res.status      = status;
    assign o_res.is_empty    = (n_count == '0);
    assign o_res.count       = n_count;
    assign o_res.front_level = n_front_lvl;
    assign o_res_elem        = n_front_elem;

    always_ff @(posedge i_clk) begin
        if (val_we) begin
            r_val_mem[val_waddr] <= val_wdata;
        end
        if (val_re) begin
            r_val_rd <= r_val_mem[val_raddr];
        end
        if (lk_we) begin
            r_lk_mem[lk_waddr] <= lk_wdata;
        end
        if (lk_re) begin
            r_lk_rd      <= r_lk_mem[lk_raddr];
            r_lk_rd_addr <= lk_raddr;
        end
        if (hd_we) begin
            r_head[hd_idx] <= hd_data;
        end
        if (tl_we) begin
            r_tail[tl_idx] <= tl_data;
        end
        r_front_node <= n_front_node;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BS_IDLE;
            r_nonempty   <= '0;
            r_free       <= '0;
            r_count      <= '0;
            r_front_lvl  <= '0;
            r_front_elem <= '0;
            r_lk_vld     <= '0;
            r_lk_rd_vld  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_nonempty   <= n_nonempty;
            r_free       <= n_free;
            r_count      <= n_count;
            r_front_lvl  <= n_front_lvl;
            r_front_elem <= n_front_elem;
            if (lk_re) begin
                r_lk_rd_vld <= r_lk_vld[lk_raddr];
            end
            if (lk_we) begin
                r_lk_vld[lk_waddr] <= 1'b1;
            end
        end
    end

endmodule

[hw/rtl/bucket_priority_queue_core.sv]
// Bucket priority queue with one FIFO list per level, level 0 most urgent.
// Every request (enqueue at a level, or dequeue of the most urgent head) gives
// exactly one result: front element and level after the request, element count,
// empty flag and status. Requests are registered and classified at the front,
// wait in a two-entry queue and are carried out by the back part, which owns the
// node pool memories. Rejected requests and dequeues that empty the queue finish
// in BS_IDLE; an accepted enqueue also passes BS_ENQ_FREE (the free list's next
// link comes from the link memory's registered read), a dequeue that empties its
// level BS_VAL, and one that does not BS_DEQ_LINK and BS_VAL (link read, then
// value read of the new head). No clearing pass is needed after reset.
module bucket_priority_queue_core #(
    parameter int ELEM_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [3:0]       i_cfg_wdata,    // lowest_level
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [((ELEM_WIDTH+4+7)/8)*8-1:0]  s_axis_tdata,  // elem, level
    input  logic             s_axis_tuser,   // cmd
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [((ELEM_WIDTH+12+7)/8)*8-1:0] m_axis_tdata,  // front_elem, front_level, count, is_empty
    output logic [1:0]       m_axis_tuser    // status
);
    import bpq_pkg::*;

    localparam int IN_W  = ((ELEM_WIDTH + LVL_W + 7) / 8) * 8;
    localparam int OUT_W = ((ELEM_WIDTH + LVL_W + CNT_W + 1 + 7) / 8) * 8;
    localparam int Q_W   = $bits(t_cmd) + ELEM_WIDTH;

    logic                  fe_push, q_full, q_vld, q_pop, slot_free, emit;
    t_cmd                  fe_cmd, q_cmd;
    logic [ELEM_WIDTH-1:0] fe_elem, q_elem, res_elem;
    logic [Q_W-1:0]        q_rdata;
    t_res                  res;
    logic [OUT_W-1:0]      n_tdata;
    logic                  r_m_vld;
    logic [OUT_W-1:0]      r_m_data;
    logic [1:0]            r_m_user;

    bpq_front #(
        .ELEM_WIDTH (ELEM_WIDTH),
        .IN_W       (IN_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_data      (s_axis_tdata),
        .i_user      (s_axis_tuser),
        .o_push      (fe_push),
        .o_cmd       (fe_cmd),
        .o_elem      (fe_elem),
        .i_full      (q_full)
    );

    bpq_cmd_fifo #(
        .W (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_push),
        .i_data  ({fe_cmd, fe_elem}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_vld   (q_vld),
        .o_data  (q_rdata)
    );

    assign q_cmd  = q_rdata[Q_W-1:ELEM_WIDTH];
    assign q_elem = q_rdata[ELEM_WIDTH-1:0];

    assign slot_free = !r_m_vld || m_axis_tready;

    bpq_back #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_vld   (q_vld),
        .i_cmd       (q_cmd),
        .i_elem      (q_elem),
        .o_pop       (q_pop),
        .i_slot_free (slot_free),
        .o_emit      (emit),
        .o_res       (res),
        .o_res_elem  (res_elem)
    );

    always_comb begin
        n_tdata                                            = '0;
        n_tdata[ELEM_WIDTH-1:0]                            = res_elem;
        n_tdata[ELEM_WIDTH +: LVL_W]                       = res.front_level;
        n_tdata[ELEM_WIDTH+LVL_W +: CNT_W]                 = res.count;
        n_tdata[ELEM_WIDTH+LVL_W+CNT_W]                    = res.is_empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (emit) begin
            r_m_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_m_data <= n_tdata;
            r_m_user <= res.status;
        end
    end

    assign m_axis_tvalid = r_m_vld;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[ELEM_WIDTH+LVL_W +: CNT_W] <= CNT_W'(CAPACITY)))
        else $error("result count above capacity");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[ELEM_WIDTH+LVL_W+CNT_W] ==
                           (m_axis_tdata[ELEM_WIDTH+LVL_W +: CNT_W] == '0)))
        else $error("empty flag disagrees with count");

    a_empty_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[ELEM_WIDTH+LVL_W+CNT_W]) |->
        (m_axis_tdata[ELEM_WIDTH+LVL_W-1:0] == '0))
        else $error("front fields not cleared on empty queue");

    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> slot_free)
        else $error("result produced while output slot occupied");
`endif

endmodule

[bench/tb_bucket_priority_queue_core.sv]
// testbench for the bucket priority queue core: directed and random requests checked against a predictor
`timescale 1ns / 1ps

module tb_bucket_priority_queue_core;
    import bpq_pkg::*;

    localparam int ELEM_W    = 32;
    localparam int IN_W      = ((ELEM_W + 4 + 7) / 8) * 8;
    localparam int OUT_W     = ((ELEM_W + 12 + 7) / 8) * 8;
    localparam int LIMIT     = 400000;
    localparam int PHASES    = 6;
    localparam int PHASE_LEN = 220;
    localparam int N_ROWS    = 21;

    typedef struct packed {
        logic [ELEM_W-1:0] front_elem;
        logic [LVL_W-1:0]  front_level;
        logic [6:0]        count;
        logic              is_empty;
        t_status           status;
    } t_front;

    typedef struct packed {
        logic              cfg_first;
        logic [3:0]        cfg_val;
        logic              cmd;
        logic [ELEM_W-1:0] elem;
        logic [LVL_W-1:0]  lvl;
        logic              typed;
        t_front            want;
    } t_req_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [3:0]       i_cfg_wdata = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata = '0;    // elem, level
    logic             s_axis_tuser = 1'b0;  // cmd
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;         // front_elem, front_level, count, is_empty
    logic [1:0]       m_axis_tuser;         // status

    logic [ELEM_W-1:0] level_fifo [LEVELS][$];
    int unsigned       held;
    logic [3:0]        limit_lvl;
    t_front            expected_fronts [$];
    int unsigned       errors = 0;
    int unsigned       cycles = 0;
    int unsigned       idle_pct = 0;
    int unsigned       stall_pct = 0;

    t_req_row directed_reqs [0:N_ROWS-1] = '{
        '{1'b0, 4'd0, CMD_DEQ, 32'h0, 4'd0, 1'b1, '{32'h0, 4'd0, 7'd0, 1'b1, ST_EMPTY}},
        '{1'b0, 4'd0, CMD_ENQ, 32'hffffffff, 4'd15, 1'b1,
          '{32'hffffffff, 4'd15, 7'd1, 1'b0, ST_OK}},
        '{1'b0, 4'd0, CMD_ENQ, 32'h0, 4'd0, 1'b1, '{32'h0, 4'd0, 7'd2, 1'b0, ST_OK}},
        '{1'b0, 4'd0, CMD_ENQ, 32'h12345678, 4'd0, 1'b0, '0},
        '{1'b0, 4'd0, CMD_ENQ, 32'h89abcdef, 4'd7, 1'b0, '0},
        '{1'b0, 4'd0, CMD_DEQ, 32'hdeadbeef, 4'd3, 1'b0, '0},
        '{1'b0, 4'd0, CMD_DEQ, 32'h0, 4'd0, 1'b0, '0},
        '{1'b1, 4'd3, CMD_ENQ, 32'h00000001, 4'd9, 1'b0, '0},
        '{1'b0, 4'd0, CMD_DEQ, 32'h0, 4'd0, 1'b0, '0},
        '{1'b0, 4'd0, CMD_ENQ, 32'h00000005, 4'd3, 1'b0, '0},
        '{1'b0, 4'd0, CMD_ENQ, 32'h00000006, 4'd4, 1'b0, '0},
        '{1'b1, 4'd0, CMD_ENQ, 32'h00000007, 4'd0, 1'b0, '0},
        '{1'b0, 4'd0, CMD_ENQ, 32'h00000008, 4'd1, 1'b0, '0},
        '{1'b0, 4'd0, CMD_DEQ, 32'h0, 4'd0, 1'b0, '0},
        '{1'b0, 4'd0, CMD_DEQ, 32'h0, 4'd0, 1'b0, '0},
        '{1'b0, 4'd0, CMD_DEQ, 32'h0, 4'd0, 1'b0, '0},
        '{1'b0, 4'd0, CMD_DEQ, 32'h0, 4'd0, 1'b1, '{32'h0, 4'd0, 7'd0, 1'b1, ST_EMPTY}},
        '{1'b1, 4'd15, CMD_ENQ, 32'h0, 4'd15, 1'b1, '{32'h0, 4'd15, 7'd1, 1'b0, ST_OK}},
        '{1'b0, 4'd0, CMD_ENQ, 32'hffffffff, 4'd15, 1'b0, '0},
        '{1'b0, 4'd0, CMD_DEQ, 32'h0, 4'd0, 1'b0, '0},
        '{1'b0, 4'd0, CMD_DEQ, 32'h0, 4'd0, 1'b1, '{32'h0, 4'd0, 7'd0, 1'b1, ST_OK}}
    };

    bucket_priority_queue_core #(
        .ELEM_WIDTH (ELEM_W)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_front bucket_queue_step(input logic cmd, input logic [ELEM_W-1:0] elem,
                                                 input logic [LVL_W-1:0] lvl);
        t_front r;
        int     top;
        r   = '0;
        top = -1;
        r.status = ST_OK;
        if (cmd == CMD_ENQ) begin
            if (lvl > limit_lvl) begin
                r.status = ST_LEVEL;
            end else if (held >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                level_fifo[lvl].push_back(elem);
                held++;
            end
        end else begin
            for (int i = LEVELS - 1; i >= 0; i--) begin
                if (level_fifo[i].size() > 0) top = i;
            end
            if (top < 0) begin
                r.status = ST_EMPTY;
            end else begin
                void'(level_fifo[top].pop_front());
                held--;
            end
        end
        top = -1;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (level_fifo[i].size() > 0) top = i;
        end
        if (top >= 0) begin
            r.front_elem  = level_fifo[top][0];
            r.front_level = LVL_W'(top);
        end
        r.count    = 7'(held);
        r.is_empty = (held == 0);
        return r;
    endfunction

    task automatic write_limit(input logic [3:0] value);
        s_axis_tvalid <= 1'b0;
        while (expected_fronts.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        limit_lvl = value;
    endtask

    task automatic send_request(input logic cmd, input logic [ELEM_W-1:0] elem,
                                input logic [LVL_W-1:0] lvl, input logic typed,
                                input t_front want);
        t_front pred;
        while ($urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= IN_W'({lvl, elem});
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pred = bucket_queue_step(cmd, elem, lvl);
        expected_fronts.push_back(typed ? want : pred);
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        t_front exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_fronts.size() == 0) begin
                $error("result with no request outstanding: tdata %h tuser %h",
                       m_axis_tdata, m_axis_tuser);
                errors++;
            end else begin
                exp_r = expected_fronts.pop_front();
                if (m_axis_tdata[31:0] !== exp_r.front_elem) begin
                    $error("front_elem: expected %h, got %h", exp_r.front_elem, m_axis_tdata[31:0]);
                    errors++;
                end
                if (m_axis_tdata[35:32] !== exp_r.front_level) begin
                    $error("front_level: expected %0d, got %0d",
                           exp_r.front_level, m_axis_tdata[35:32]);
                    errors++;
                end
                if (m_axis_tdata[42:36] !== exp_r.count) begin
                    $error("count: expected %0d, got %0d", exp_r.count, m_axis_tdata[42:36]);
                    errors++;
                end
                if (m_axis_tdata[43] !== exp_r.is_empty) begin
                    $error("is_empty: expected %0d, got %0d", exp_r.is_empty, m_axis_tdata[43]);
                    errors++;
                end
                if (m_axis_tuser !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        logic [3:0]        lim;
        logic              cmd;
        logic [LVL_W-1:0]  lvl;
        int unsigned       enq_pct;
        held      = 0;
        limit_lvl = 4'd15;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_ROWS; r++) begin
            if (directed_reqs[r].cfg_first) write_limit(directed_reqs[r].cfg_val);
            send_request(directed_reqs[r].cmd, directed_reqs[r].elem, directed_reqs[r].lvl,
                         directed_reqs[r].typed, directed_reqs[r].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       lim = 4'd0;
                1:       lim = 4'd7;
                2:       lim = 4'd15;
                3:       lim = 4'd3;
                4:       lim = 4'($urandom_range(1, 14));
                default: lim = 4'd15;
            endcase
            write_limit(lim);
            case (p % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 82; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 82; end
                default: begin idle_pct = 37; stall_pct = 37; end
            endcase
            for (int i = 0; i < PHASE_LEN; i++) begin
                // fill towards full first, then drain back past empty
                enq_pct = (i < PHASE_LEN / 2) ? 90 : 20;
                cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
                if ($urandom_range(0, 99) < 85) lvl = LVL_W'($urandom_range(0, limit_lvl));
                else                            lvl = LVL_W'($urandom_range(0, LEVELS - 1));
                send_request(cmd, $urandom, lvl, 1'b0, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (expected_fronts.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[bucket_priority_queue_core.f]
hw/rtl/bpq_pkg.sv
hw/rtl/bpq_cmd_fifo.sv
hw/rtl/bpq_front.sv
hw/rtl/bpq_back.sv
hw/rtl/bucket_priority_queue_core.sv
bench/tb_bucket_priority_queue_core.sv
